FILE: rtl/core/tetd_pkg.sv
// ----------------------------------------------------------------------------
// tetd_pkg: shared types for the track end transition detector
// Beat layouts, configuration record, sticky state and transition mode codes.
// ----------------------------------------------------------------------------
package tetd_pkg;

  // Transition mode reported with every result
  typedef enum logic [1:0] {
    MODE_NONE    = 2'd0,
    MODE_XFADE   = 2'd1,
    MODE_GAPLESS = 2'd2
  } mode_t;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_BOUNDARY_EN = 3'd0;
  localparam logic [2:0] REG_XFADE_EN    = 3'd1;
  localparam logic [2:0] REG_GAPLESS_EN  = 3'd2;
  localparam logic [2:0] REG_FADE_OUT    = 3'd3;
  localparam logic [2:0] REG_FADE_IN     = 3'd4;
  localparam logic [2:0] REG_GAPLESS_LD  = 3'd5;
  localparam logic [2:0] REG_DELAY       = 3'd6;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;
  localparam int unsigned IN_DW  = 104;
  localparam int unsigned OUT_DW = 8;

  // Configuration record
  typedef struct packed {
    logic        boundary_enable;
    logic        crossfade_enable;
    logic        gapless_enable;
    logic [15:0] fade_out_ms;
    logic [15:0] fade_in_ms;
    logic [15:0] gapless_lead_ms;
    logic [15:0] delay_ms;
  } cfg_t;

  // One input beat, unpacked
  typedef struct packed {
    logic        command;
    logic [31:0] position_ms;
    logic [31:0] duration_ms;
    logic        end_of_input;
    logic        buffer_empty;
    logic [31:0] remaining_ms;
  } item_t;

  // Sticky per-track state
  typedef struct packed {
    logic  boundary_seen;
    logic  ending_flag;
    logic  switch_flag;
    mode_t mode;
  } state_t;

  // Result beat, lowest field in the lowest bit
  typedef struct packed {
    mode_t transition_mode;
    logic  ready_to_switch;
    logic  end_reached;
    logic  about_to_finish;
    logic  boundary_hit;
  } result_t;

  // Position has entered the window of width win before the duration.
  // pos >= dur - win (floored at zero) is the same as pos + win >= dur.
  function automatic logic time_hit(input logic [31:0] pos, input logic [31:0] dur,
                                    input logic [16:0] win, input logic tl);
    logic [32:0] sum;
    sum = {1'b0, pos} + {16'd0, win};
    return tl && (dur != 32'd0) && (sum >= {1'b0, dur});
  endfunction

  // Window reached by time or by draining buffered output
  function automatic logic lead_ready(input logic [16:0] win, input logic tl,
                                      input logic [31:0] pos, input logic [31:0] dur,
                                      input logic eoi, input logic [31:0] rem);
    return time_hit(pos, dur, win, tl) || (eoi && (rem <= {15'd0, win}));
  endfunction

endpackage

FILE: rtl/core/track_end_transition_detector.sv
// ----------------------------------------------------------------------------
// track_end_transition_detector: track end and transition detector
// Sticky boundary / ending / switch flags with crossfade or gapless selection.
// ----------------------------------------------------------------------------
//  Channel  | Ports                      | Beat contents
//  ---------+----------------------------+------------------------------------
//  input    | in_tvalid/tready/tdata/tuser | status or clear command
//  result   | out_tvalid/tready/tdata    | one result per input beat
//  config   | cfg_psel..cfg_pready       | seven registers, 4-byte stride
//
//  One beat per cycle sustained while the result channel is not stalled;
//  path: input register, decision logic, result register.
//  The sticky state updates in the same cycle the beat moves to the result
//  register, so a beat in the next cycle sees it.
//  Reset (rst_n low, synchronous) clears state and both valids, not payloads.
//  A stalled result holds; the input register takes a beat whenever it is
//  empty, or the result register is empty or drains in that cycle.
// ----------------------------------------------------------------------------
module track_end_transition_detector import tetd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input beat
  input  logic              in_tvalid,
  output logic              in_tready,
  // [31:0] position_ms, [63:32] duration_ms, [64] end_of_input,
  // [65] buffer_empty, [97:66] remaining_ms, [103:98] zero
  input  logic [IN_DW-1:0]  in_tdata,
  // [0] command
  input  logic              in_tuser,
  // result beat
  output logic              out_tvalid,
  input  logic              out_tready,
  // [0] boundary_hit, [1] about_to_finish, [2] end_reached,
  // [3] ready_to_switch, [5:4] transition_mode, [7:6] zero
  output logic [OUT_DW-1:0] out_tdata,
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t    cfg;
  item_t   item_r;
  item_t   item_nxt;
  logic    in_v_r;
  logic    in_v_nxt;
  logic    out_v_r;
  logic    out_v_nxt;
  result_t res_r;
  result_t res_nxt;
  state_t  st_r;
  state_t  st_nxt;
  state_t  st_eval;
  result_t res_eval;
  logic    out_free;
  logic    adv;
  logic    in_fire;

  assign cfg_pready = 1'b1;

  tetd_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg         (cfg)
  );

  // Handshake: result register frees the input register
  assign out_free  = !out_v_r || out_tready;
  assign adv       = in_v_r && out_free;
  assign in_tready = !in_v_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  // Input register
  always_comb begin
    in_v_nxt = in_fire || (in_v_r && !adv);
    item_nxt = item_r;
    if (in_fire) begin
      item_nxt.command      = in_tuser;
      item_nxt.position_ms  = in_tdata[31:0];
      item_nxt.duration_ms  = in_tdata[63:32];
      item_nxt.end_of_input = in_tdata[64];
      item_nxt.buffer_empty = in_tdata[65];
      item_nxt.remaining_ms = in_tdata[97:66];
    end
  end

  tetd_eval u_eval (
    .cfg    (cfg),
    .item   (item_r),
    .st     (st_r),
    .st_nxt (st_eval),
    .res    (res_eval)
  );

  // Result register and sticky state
  always_comb begin
    out_v_nxt = adv || (out_v_r && !out_tready);
    res_nxt   = adv ? res_eval : res_r;
    st_nxt    = adv ? st_eval : st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= '0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      st_r    <= st_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, res_r};

endmodule

FILE: rtl/core/tetd_regs.sv
// ----------------------------------------------------------------------------
// tetd_regs: configuration register file
// APB-style write and read of the seven detector registers.
// ----------------------------------------------------------------------------
module tetd_regs import tetd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output cfg_t              cfg
);

  cfg_t        cfg_r;
  cfg_t        cfg_nxt;
  logic        wr_en;
  logic [2:0]  idx;

  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx   = cfg_paddr[4:2];
  assign cfg   = cfg_r;

  // Write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_BOUNDARY_EN: cfg_nxt.boundary_enable  = cfg_pwdata[0];
        REG_XFADE_EN:    cfg_nxt.crossfade_enable = cfg_pwdata[0];
        REG_GAPLESS_EN:  cfg_nxt.gapless_enable   = cfg_pwdata[0];
        REG_FADE_OUT:    cfg_nxt.fade_out_ms      = cfg_pwdata[15:0];
        REG_FADE_IN:     cfg_nxt.fade_in_ms       = cfg_pwdata[15:0];
        REG_GAPLESS_LD:  cfg_nxt.gapless_lead_ms  = cfg_pwdata[15:0];
        REG_DELAY:       cfg_nxt.delay_ms         = cfg_pwdata[15:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read decode
  always_comb begin
    unique case (idx)
      REG_BOUNDARY_EN: cfg_prdata = {31'd0, cfg_r.boundary_enable};
      REG_XFADE_EN:    cfg_prdata = {31'd0, cfg_r.crossfade_enable};
      REG_GAPLESS_EN:  cfg_prdata = {31'd0, cfg_r.gapless_enable};
      REG_FADE_OUT:    cfg_prdata = {16'd0, cfg_r.fade_out_ms};
      REG_FADE_IN:     cfg_prdata = {16'd0, cfg_r.fade_in_ms};
      REG_GAPLESS_LD:  cfg_prdata = {16'd0, cfg_r.gapless_lead_ms};
      REG_DELAY:       cfg_prdata = {16'd0, cfg_r.delay_ms};
      default:         cfg_prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/tetd_eval.sv
// ----------------------------------------------------------------------------
// tetd_eval: per-beat decision logic
// Boundary, ending, switch and mode decisions from one beat and the state.
// ----------------------------------------------------------------------------
module tetd_eval import tetd_pkg::*; (
  input  cfg_t    cfg,
  input  item_t   item,
  input  state_t  st,
  output state_t  st_nxt,
  output result_t res
);

  logic [16:0] w_xf;
  logic [16:0] w_gl;
  logic [16:0] w_ov;
  logic [15:0] ov_len;
  logic        at_b;
  logic        hard_end;
  logic        xf_ready;
  logic        gl_ready;
  logic        decide;
  mode_t       dec_mode;
  mode_t       mode_mid;
  logic        ending_mid;
  logic        sw_dec;

  // Window widths: 16-bit length plus delay never overflows 17 bits
  assign ov_len = (cfg.fade_out_ms < cfg.fade_in_ms) ? cfg.fade_out_ms : cfg.fade_in_ms;
  assign w_xf   = {1'b0, cfg.fade_out_ms} + {1'b0, cfg.delay_ms};
  assign w_gl   = {1'b0, cfg.gapless_lead_ms} + {1'b0, cfg.delay_ms};
  assign w_ov   = {1'b0, ov_len} + {1'b0, cfg.delay_ms};

  assign at_b     = cfg.boundary_enable && (item.duration_ms != 32'd0) &&
                    (item.position_ms >= item.duration_ms);
  assign hard_end = item.end_of_input && item.buffer_empty;

  // Ending decision: crossfade wins over gapless
  assign xf_ready = cfg.crossfade_enable &&
                    lead_ready(w_xf, cfg.boundary_enable, item.position_ms,
                               item.duration_ms, item.end_of_input, item.remaining_ms);
  assign gl_ready = cfg.gapless_enable &&
                    (item.end_of_input ||
                     lead_ready(w_gl, cfg.boundary_enable, item.position_ms,
                                item.duration_ms, item.end_of_input, item.remaining_ms));
  assign dec_mode = (xf_ready || gl_ready) ?
                    (cfg.crossfade_enable ? MODE_XFADE : MODE_GAPLESS) : MODE_NONE;
  assign decide   = xf_ready || gl_ready || at_b ||
                    (!(cfg.crossfade_enable || cfg.gapless_enable) && item.end_of_input);

  // Mode only moves when the ending decision is actually taken
  assign mode_mid   = st.ending_flag ? st.mode : dec_mode;
  assign ending_mid = st.ending_flag || decide;

  // Switch readiness, timeline always on
  always_comb begin
    case (mode_mid)
      MODE_XFADE:   sw_dec = lead_ready(w_ov, 1'b1, item.position_ms, item.duration_ms,
                                        item.end_of_input, item.remaining_ms);
      MODE_GAPLESS: sw_dec = lead_ready(w_gl, 1'b1, item.position_ms, item.duration_ms,
                                        item.end_of_input, item.remaining_ms);
      default:      sw_dec = 1'b0;
    endcase
  end

  // Next state and result
  always_comb begin
    st_nxt = st;
    res    = '0;
    if (item.command) begin
      st_nxt = '0;
    end else begin
      res.boundary_hit     = !st.boundary_seen && (at_b || hard_end);
      st_nxt.boundary_seen = st.boundary_seen || at_b || hard_end;
      if (hard_end) begin
        st_nxt.ending_flag = 1'b1;
        st_nxt.switch_flag = 1'b0;
        st_nxt.mode        = MODE_NONE;
        res.end_reached    = 1'b1;
      end else begin
        st_nxt.ending_flag  = ending_mid;
        st_nxt.mode         = mode_mid;
        res.about_to_finish = !st.ending_flag && decide;
        res.end_reached     = at_b;
        if (ending_mid && !st.switch_flag && sw_dec) begin
          st_nxt.switch_flag  = 1'b1;
          res.ready_to_switch = 1'b1;
        end
      end
    end
    res.transition_mode = st_nxt.mode;
  end

endmodule

FILE: rtl/core/tetd_checker.sv
// ----------------------------------------------------------------------------
// tetd_checker: port-level checks for the detector
// Result channel hold, field consistency and input readiness.
// ----------------------------------------------------------------------------
module tetd_checker import tetd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Empty result register never back-pressures the input
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // Mode code 3 is never produced
  a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[5:4] != 2'd3)
    else $error("illegal transition mode");

  // Switch readiness needs a live transition mode
  a_switch_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tdata[5:4] != 2'd0)
    else $error("ready_to_switch without transition mode");

  // Boundary hit always comes with an end report
  a_hit_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[2])
    else $error("boundary_hit without end_reached");

endmodule

bind track_end_transition_detector tetd_checker u_tetd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/tb_track_end_transition_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_track_end_transition_detector: self-checking bench for the detector
// Streams evaluate and clear beats through the block under several register
// settings, predicts every result beat in-bench and compares field by field.
// Covers hard end, unknown duration, crossfade over gapless, back-pressure.
// ----------------------------------------------------------------------------
module tb_track_end_transition_detector import tetd_pkg::*; ();

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  // [31:0] position_ms, [63:32] duration_ms, [64] end_of_input,
  // [65] buffer_empty, [97:66] remaining_ms, [103:98] zero
  logic [IN_DW-1:0]  in_tdata    = '0;
  // [0] command
  logic              in_tuser    = 1'b0;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  // [0] boundary_hit, [1] about_to_finish, [2] end_reached,
  // [3] ready_to_switch, [5:4] transition_mode, [7:6] zero
  logic [OUT_DW-1:0] out_tdata;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // Shadow registers and sticky track state of the predictor
  cfg_t    shadow_cfg  = '0;
  logic    bnd_seen    = 1'b0;
  logic    ending      = 1'b0;
  logic    switched    = 1'b0;
  mode_t   cur_mode    = MODE_NONE;
  result_t expected_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  int beats_sent    = 0;
  int mismatches    = 0;
  result_t got_beat, want_beat;

  track_end_transition_detector uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #2 clk = ~clk;

  // Run limit
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Window of width win before the duration reached by time, or by draining
  function automatic logic window_ok(input logic [16:0] win, input logic use_tl,
                                     input logic [31:0] pos, input logic [31:0] dur,
                                     input logic eoi, input logic [31:0] rem);
    logic [32:0] trigger;
    logic        by_time;
    trigger = ({1'b0, dur} > {16'd0, win}) ? {1'b0, dur} - {16'd0, win} : 33'd0;
    by_time = use_tl && (dur != 32'd0) && ({1'b0, pos} >= trigger);
    return by_time || (eoi && ({1'b0, rem} <= {16'd0, win}));
  endfunction

  // Expected result of one beat; updates the sticky state
  function automatic result_t predict_status(input item_t it);
    result_t     r;
    logic        tl, at_bound, xf_rdy, gl_rdy, finish_now, switch_now;
    logic [15:0] overlap;
    logic [16:0] xf_win, gl_win, ov_win;
    r          = '0;
    tl         = shadow_cfg.boundary_enable;
    overlap    = (shadow_cfg.fade_out_ms < shadow_cfg.fade_in_ms) ?
                 shadow_cfg.fade_out_ms : shadow_cfg.fade_in_ms;
    xf_win     = {1'b0, shadow_cfg.fade_out_ms} + {1'b0, shadow_cfg.delay_ms};
    gl_win     = {1'b0, shadow_cfg.gapless_lead_ms} + {1'b0, shadow_cfg.delay_ms};
    ov_win     = {1'b0, overlap} + {1'b0, shadow_cfg.delay_ms};
    switch_now = 1'b0;
    if (it.command) begin
      bnd_seen = 1'b0;
      ending   = 1'b0;
      switched = 1'b0;
      cur_mode = MODE_NONE;
    end else begin
      at_bound = tl && (it.duration_ms != 32'd0) && (it.position_ms >= it.duration_ms);
      if (!bnd_seen && at_bound) begin
        bnd_seen       = 1'b1;
        r.boundary_hit = 1'b1;
      end
      if (it.end_of_input && it.buffer_empty) begin
        // hard end
        ending   = 1'b1;
        switched = 1'b0;
        if (!bnd_seen) begin
          bnd_seen       = 1'b1;
          r.boundary_hit = 1'b1;
        end
        cur_mode      = MODE_NONE;
        r.end_reached = 1'b1;
      end else begin
        if (!ending) begin
          xf_rdy = shadow_cfg.crossfade_enable &&
                   window_ok(xf_win, tl, it.position_ms, it.duration_ms,
                             it.end_of_input, it.remaining_ms);
          gl_rdy = shadow_cfg.gapless_enable &&
                   (it.end_of_input ||
                    window_ok(gl_win, tl, it.position_ms, it.duration_ms,
                              it.end_of_input, it.remaining_ms));
          if (xf_rdy || gl_rdy) begin
            // crossfade wins over gapless
            cur_mode   = shadow_cfg.crossfade_enable ? MODE_XFADE : MODE_GAPLESS;
            finish_now = 1'b1;
          end else begin
            cur_mode   = MODE_NONE;
            finish_now = at_bound ||
                         (!(shadow_cfg.crossfade_enable || shadow_cfg.gapless_enable) &&
                          it.end_of_input);
          end
          if (finish_now) begin
            ending            = 1'b1;
            r.about_to_finish = 1'b1;
          end
        end
        if (at_bound) r.end_reached = 1'b1;
        if (ending && !switched) begin
          case (cur_mode)
            MODE_XFADE:   switch_now = window_ok(ov_win, 1'b1, it.position_ms,
                                                 it.duration_ms, it.end_of_input,
                                                 it.remaining_ms);
            MODE_GAPLESS: switch_now = window_ok(gl_win, 1'b1, it.position_ms,
                                                 it.duration_ms, it.end_of_input,
                                                 it.remaining_ms);
            default:      switch_now = 1'b0;
          endcase
          if (switch_now) begin
            switched          = 1'b1;
            r.ready_to_switch = 1'b1;
          end
        end
      end
    end
    r.transition_mode = cur_mode;
    return r;
  endfunction

  function automatic item_t make_status(input logic cmd, input logic [31:0] pos,
                                        input logic [31:0] dur, input logic eoi,
                                        input logic empty, input logic [31:0] rem);
    item_t it;
    it.command      = cmd;
    it.position_ms  = pos;
    it.duration_ms  = dur;
    it.end_of_input = eoi;
    it.buffer_empty = empty;
    it.remaining_ms = rem;
    return it;
  endfunction

  // Offer one beat, predict its result at acceptance; valid stays high after
  task automatic send_status(input item_t it);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, it.remaining_ms, it.buffer_empty, it.end_of_input,
                  it.duration_ms, it.position_ms};
    in_tuser  <= it.command;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_status(it));
    beats_sent++;
  endtask

  // Stop sending and let every expected result drain, plus pipeline slack
  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write; psel stays up so back-to-back writes need no idle cycle
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_BOUNDARY_EN: shadow_cfg.boundary_enable  = val[0];
      REG_XFADE_EN:    shadow_cfg.crossfade_enable = val[0];
      REG_GAPLESS_EN:  shadow_cfg.gapless_enable   = val[0];
      REG_FADE_OUT:    shadow_cfg.fade_out_ms      = val[15:0];
      REG_FADE_IN:     shadow_cfg.fade_in_ms       = val[15:0];
      REG_GAPLESS_LD:  shadow_cfg.gapless_lead_ms  = val[15:0];
      REG_DELAY:       shadow_cfg.delay_ms         = val[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(REG_BOUNDARY_EN, {31'd0, c.boundary_enable});
    write_reg(REG_XFADE_EN,    {31'd0, c.crossfade_enable});
    write_reg(REG_GAPLESS_EN,  {31'd0, c.gapless_enable});
    write_reg(REG_FADE_OUT,    {16'd0, c.fade_out_ms});
    write_reg(REG_FADE_IN,     {16'd0, c.fade_in_ms});
    write_reg(REG_GAPLESS_LD,  {16'd0, c.gapless_lead_ms});
    write_reg(REG_DELAY,       {16'd0, c.delay_ms});
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Rotate through max, zero-length and random settings
  function automatic cfg_t pick_config(input int k);
    cfg_t c;
    c.boundary_enable  = 1'($urandom_range(0, 1));
    c.crossfade_enable = 1'($urandom_range(0, 1));
    c.gapless_enable   = 1'($urandom_range(0, 1));
    case (k % 4)
      0: begin
        c = '1;
      end
      1: begin
        c.fade_out_ms     = '0;
        c.fade_in_ms      = '0;
        c.gapless_lead_ms = '0;
        c.delay_ms        = '0;
      end
      default: begin
        c.fade_out_ms     = 16'($urandom_range(0, 1) ? $urandom_range(0, 3000) : $urandom);
        c.fade_in_ms      = 16'($urandom_range(0, 1) ? $urandom_range(0, 3000) : $urandom);
        c.gapless_lead_ms = 16'($urandom_range(0, 1) ? $urandom_range(0, 3000) : $urandom);
        c.delay_ms        = 16'($urandom_range(0, 1) ? $urandom_range(0, 2000) : $urandom);
      end
    endcase
    return c;
  endfunction

  // One track: position walks toward and past the duration, end of input
  // arrives somewhere along the way and the buffer drains; a clear usually follows
  task automatic play_track();
    logic [31:0] dur, span, pos, stride, drain;
    logic        eoi, empty;
    int          n, eoi_from;
    n = $urandom_range(3, 14);
    case ($urandom_range(0, 9))
      0:       dur = 32'd0;
      1:       dur = $urandom;
      default: dur = $urandom_range(1, 400000);
    endcase
    span     = $urandom_range(1, 150000);
    pos      = (dur > span) ? dur - span : 32'd0;
    stride   = span / (n - 2) + 1;
    drain    = span + $urandom_range(0, 5000);
    eoi_from = $urandom_range(1, n);
    for (int i = 0; i < n; i++) begin
      // noise beat now and then
      if ($urandom_range(0, 19) == 0)
        send_status(make_status($urandom_range(0, 7) == 0, $urandom, $urandom,
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                $urandom));
      eoi   = (i >= eoi_from);
      empty = eoi ? ((i == n - 1) && $urandom_range(0, 1)) : ($urandom_range(0, 29) == 0);
      send_status(make_status(1'b0, pos, dur, eoi, empty,
                              eoi ? drain : $urandom_range(0, 300000)));
      pos   = (pos > 32'hFFFF_FFFF - stride) ? 32'hFFFF_FFFF : pos + stride;
      drain = (drain > stride) ? drain - stride : 32'd0;
    end
    if ($urandom_range(0, 6) != 0)
      send_status(make_status(1'b1, $urandom, $urandom, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), $urandom));
  endtask

  // Directed: field extremes, clear, hard end, unknown duration, precedence
  task automatic test_directed();
    cfg_t c;
    c = '0;
    apply_config(c);
    send_status(make_status(1'b0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0));
    send_status(make_status(1'b0, 32'd0, 32'd0, 1'b1, 1'b0, 32'hFFFF_FFFF));
    send_status(make_status(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF));
    send_status(make_status(1'b0, 32'd5, 32'd100, 1'b1, 1'b1, 32'd0));
    send_status(make_status(1'b1, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0));
    wait_results();
    c = '{boundary_enable: 1'b1, crossfade_enable: 1'b1, gapless_enable: 1'b1,
          fade_out_ms: 16'd1000, fade_in_ms: 16'd400, gapless_lead_ms: 16'd2000,
          delay_ms: 16'd100};
    apply_config(c);
    send_status(make_status(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0));
    send_status(make_status(1'b1, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0));
    // gapless window opens first, crossfade still chosen
    send_status(make_status(1'b0, 32'd8000, 32'd10000, 1'b0, 1'b0, 32'd50000));
    send_status(make_status(1'b0, 32'd9600, 32'd10000, 1'b0, 1'b0, 32'd50000));
    send_status(make_status(1'b0, 32'd10000, 32'd10000, 1'b0, 1'b0, 32'd50000));
    send_status(make_status(1'b1, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0));
    // unknown duration: only drain and end of input count
    send_status(make_status(1'b0, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0, 32'd0));
    send_status(make_status(1'b0, 32'd0, 32'd0, 1'b1, 1'b0, 32'd2000));
    send_status(make_status(1'b0, 32'd0, 32'd0, 1'b1, 1'b0, 32'd500));
    send_status(make_status(1'b0, 32'd0, 32'd0, 1'b1, 1'b1, 32'd0));
    send_status(make_status(1'b1, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0));
    wait_results();
    c = '{boundary_enable: 1'b0, crossfade_enable: 1'b0, gapless_enable: 1'b1,
          fade_out_ms: 16'hFFFF, fade_in_ms: 16'hFFFF, gapless_lead_ms: 16'hFFFF,
          delay_ms: 16'hFFFF};
    apply_config(c);
    send_status(make_status(1'b0, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'hFFFF_FFFF));
    send_status(make_status(1'b0, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'hFFFF_FFFF));
    send_status(make_status(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0,
                            32'hFFFF_FFFF));
    send_status(make_status(1'b1, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0));
    send_status(make_status(1'b0, 32'd0, 32'd10, 1'b0, 1'b1, 32'd0));
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int n_beats);
    int stop_at, next_cfg, k;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at       = beats_sent + n_beats;
    next_cfg      = beats_sent;
    k             = 0;
    while (beats_sent < stop_at) begin
      if (beats_sent >= next_cfg) begin
        wait_results();
        apply_config(pick_config(k));
        k++;
        next_cfg = beats_sent + $urandom_range(60, 160);
      end
      if ($urandom_range(0, 19) == 0) wait_results();
      play_track();
    end
  endtask

  // Receiver stalls for a long stretch while beats keep coming
  task automatic test_receiver_hold();
    wait_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_config(pick_config(2));
    @(negedge clk);
    hold_left = 300;
    @(posedge clk);
    while (hold_left > 0) play_track();
  endtask

  // Sender waits until every result is back before the next track
  task automatic test_pause_until_empty();
    send_idle_pct = 0;
    recv_idle_pct = 50;
    repeat (3) begin
      play_track();
      wait_results();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 15;
    recv_idle_pct = 83;
    test_directed();
    test_random_traffic(15, 83, 530);
    test_random_traffic(83, 15, 530);
    test_receiver_hold();
    test_pause_until_empty();
    test_random_traffic(0, 0, 540);
    wait_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result ready: random idling, or a counted hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic compare_field(input string fname, input logic [1:0] want,
                               input logic [1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatches++;
    end
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_beat = result_t'(out_tdata[5:0]);
      if (expected_results.size() == 0) begin
        $error("result beat %h with no expectation pending", out_tdata);
        mismatches++;
      end else begin
        want_beat = expected_results.pop_front();
        compare_field("boundary_hit", {1'b0, want_beat.boundary_hit},
                      {1'b0, got_beat.boundary_hit});
        compare_field("about_to_finish", {1'b0, want_beat.about_to_finish},
                      {1'b0, got_beat.about_to_finish});
        compare_field("end_reached", {1'b0, want_beat.end_reached},
                      {1'b0, got_beat.end_reached});
        compare_field("ready_to_switch", {1'b0, want_beat.ready_to_switch},
                      {1'b0, got_beat.ready_to_switch});
        compare_field("transition_mode", want_beat.transition_mode,
                      got_beat.transition_mode);
      end
    end
  end

endmodule
